// ----- design/csplru_pkg.sv -----
package csplru_pkg;

    localparam int WAYS      = 4;
    localparam int TAG_BITS  = 20;
    localparam int DATA_BITS = 32;
    localparam int TTL_BITS  = 8;
    localparam int CFG_BITS  = 8;
    localparam int CMD_BITS  = 2;

    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NOP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FETCH,
        ST_UPDATE,
        ST_TOUCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic high;
    } way_flags_t;

    typedef struct packed {
        logic match;
        logic better;
    } unit_stat_t;

endpackage

// ----- design/csplru_ifs.sv -----
interface csplru_req_if #(
    parameter int TAG_BITS  = csplru_pkg::TAG_BITS,
    parameter int DATA_BITS = csplru_pkg::DATA_BITS
);
    logic                          valid;
    logic                          ready;
    logic [csplru_pkg::CMD_BITS-1:0] cmd;
    logic [TAG_BITS-1:0]           tag;
    logic [DATA_BITS-1:0]          write_data;
    logic [DATA_BITS-1:0]          fill_data;

    modport source (output valid, cmd, tag, write_data, fill_data, input ready);
    modport sink   (input valid, cmd, tag, write_data, fill_data, output ready);
endinterface

interface csplru_rsp_if #(
    parameter int TAG_BITS  = csplru_pkg::TAG_BITS,
    parameter int DATA_BITS = csplru_pkg::DATA_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [DATA_BITS-1:0] read_data;
    logic                 writeback_valid;
    logic [TAG_BITS-1:0]  writeback_tag;
    logic [DATA_BITS-1:0] writeback_data;

    modport source (output valid, hit, read_data, writeback_valid, writeback_tag,
                    writeback_data, input ready);
    modport sink   (input valid, hit, read_data, writeback_valid, writeback_tag,
                    writeback_data, output ready);
endinterface

interface csplru_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csplru_pkg::CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/csplru_ram.sv -----
module csplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/csplru_way_unit.sv -----
module csplru_way_unit #(
    parameter int TAG_BITS  = csplru_pkg::TAG_BITS,
    parameter int TTL_BITS  = csplru_pkg::TTL_BITS,
    parameter int RANK_BITS = 3
) (
    input  csplru_pkg::way_flags_t flags,
    input  logic [TTL_BITS-1:0]    life,
    input  logic [RANK_BITS-1:0]   rank,
    input  logic [TAG_BITS-1:0]    way_tag,
    input  logic [TAG_BITS-1:0]    acc_tag,
    input  logic                   best_found,
    input  logic                   best_low,
    input  logic [RANK_BITS-1:0]   best_rank,
    input  logic [RANK_BITS-1:0]   w_rank,
    input  logic                   fresh,
    input  logic                   is_self,
    output csplru_pkg::unit_stat_t stat,
    output logic                   tick_high,
    output logic [TTL_BITS-1:0]    tick_life,
    output logic [RANK_BITS-1:0]   touch_rank
);

    logic low;

    assign low = !flags.high;

    always_comb
    begin
        stat.match  = flags.valid && (way_tag == acc_tag);
        // low priority beats high, then older rank wins, ties keep the earlier way
        stat.better = !best_found || (low && !best_low) ||
                      ((low == best_low) && (rank > best_rank));
    end

    always_comb
    begin
        tick_high = flags.high;
        tick_life = life;
        if (flags.valid && flags.high)
        begin
            if (life == '0)
            begin
                tick_high = 1'b0;
            end
            else
            begin
                tick_life = life - TTL_BITS'(1);
            end
        end
    end

    always_comb
    begin
        if (is_self)
        begin
            touch_rank = RANK_BITS'(1);
        end
        else if (flags.valid && (fresh || (rank < w_rank)))
        begin
            touch_rank = rank + RANK_BITS'(1);
        end
        else
        begin
            touch_rank = rank;
        end
    end

endmodule

// ----- design/cache_set_priority_lru_top.sv -----
// One write-back, write-allocate cache set with two-priority LRU replacement. For a read or
// write, one pass over the ways compares the tags and picks the victim (each way is read from
// the registered tag/data RAM in ST_SCAN_RD and compared in ST_SCAN_CMP), ST_FETCH reads the
// chosen entry, ST_UPDATE writes it, a second pass re-ranks the ways, then ST_DONE offers the
// result until rsp.ready takes it and the set returns to idle. A tick makes one pass over the
// ways; command three goes straight to ST_DONE. All passes go through one shared way unit,
// and the set takes a new item only after the result of the last one has been taken.
// ttl_reload may be written at any time the set is idle.
module cache_set_priority_lru_top #(
    parameter int WAYS      = csplru_pkg::WAYS,
    parameter int TAG_BITS  = csplru_pkg::TAG_BITS,
    parameter int DATA_BITS = csplru_pkg::DATA_BITS,
    parameter int TTL_BITS  = csplru_pkg::TTL_BITS
) (
    input logic          clk,
    input logic          rst_n,
    csplru_req_if.sink   req,
    csplru_rsp_if.source rsp,
    csplru_cfg_if.sink   cfg
);

    localparam int IDX_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_BITS  = $clog2(WAYS + 1);
    localparam int ENTRY_BITS = TAG_BITS + DATA_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(WAYS - 1);

    csplru_pkg::state_t state_reg, state_next;

    logic [IDX_BITS-1:0]             idx_reg, idx_next;
    logic [csplru_pkg::CMD_BITS-1:0] cmd_reg, cmd_next;
    logic [TAG_BITS-1:0]             tag_reg, tag_next;
    logic [DATA_BITS-1:0]            wdata_reg, wdata_next;
    logic [DATA_BITS-1:0]            fdata_reg, fdata_next;
    logic [TTL_BITS-1:0]             ttl_reg, ttl_next;

    logic [WAYS-1:0]      valid_reg, valid_next;
    logic [WAYS-1:0]      dirty_reg, dirty_next;
    logic [WAYS-1:0]      high_reg, high_next;
    logic [TTL_BITS-1:0]  life_reg [WAYS];
    logic [TTL_BITS-1:0]  life_next [WAYS];
    logic [RANK_BITS-1:0] rank_reg [WAYS];
    logic [RANK_BITS-1:0] rank_next [WAYS];

    logic                 hit_reg, hit_next;
    logic [IDX_BITS-1:0]  pos_reg, pos_next;
    logic [RANK_BITS-1:0] pos_rank_reg, pos_rank_next;
    logic                 vic_found_reg, vic_found_next;
    logic                 vic_inv_reg, vic_inv_next;
    logic                 vic_low_reg, vic_low_next;
    logic                 vic_dirty_reg, vic_dirty_next;
    logic [IDX_BITS-1:0]  vic_reg, vic_next;
    logic [RANK_BITS-1:0] vic_rank_reg, vic_rank_next;
    logic [IDX_BITS-1:0]  w_reg, w_next;
    logic [RANK_BITS-1:0] w_rank_reg, w_rank_next;
    logic                 fresh_reg, fresh_next;

    logic                 o_hit_reg, o_hit_next;
    logic [DATA_BITS-1:0] o_rdata_reg, o_rdata_next;
    logic                 o_wbv_reg, o_wbv_next;
    logic [TAG_BITS-1:0]  o_wbtag_reg, o_wbtag_next;
    logic [DATA_BITS-1:0] o_wbdata_reg, o_wbdata_next;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [IDX_BITS-1:0]   ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [TAG_BITS-1:0]   old_tag;
    logic [DATA_BITS-1:0]  old_block;

    csplru_pkg::way_flags_t cur_flags;
    csplru_pkg::unit_stat_t stat;
    logic                   tick_high;
    logic [TTL_BITS-1:0]    tick_life;
    logic [RANK_BITS-1:0]   touch_rank;
    logic [DATA_BITS-1:0]   new_block;
    logic [WAYS-1:0]        rank_one;

    // entry layout: tag above block
    csplru_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (WAYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign old_tag   = ram_rdata[ENTRY_BITS-1:DATA_BITS];
    assign old_block = ram_rdata[DATA_BITS-1:0];

    always_comb
    begin
        cur_flags.valid = valid_reg[idx_reg];
        cur_flags.high  = high_reg[idx_reg];
    end

    csplru_way_unit #(
        .TAG_BITS  (TAG_BITS),
        .TTL_BITS  (TTL_BITS),
        .RANK_BITS (RANK_BITS)
    ) u_way_unit (
        .flags      (cur_flags),
        .life       (life_reg[idx_reg]),
        .rank       (rank_reg[idx_reg]),
        .way_tag    (old_tag),
        .acc_tag    (tag_reg),
        .best_found (vic_found_reg),
        .best_low   (vic_low_reg),
        .best_rank  (vic_rank_reg),
        .w_rank     (w_rank_reg),
        .fresh      (fresh_reg),
        .is_self    (idx_reg == w_reg),
        .stat       (stat),
        .tick_high  (tick_high),
        .tick_life  (tick_life),
        .touch_rank (touch_rank)
    );

    assign req.ready = (state_reg == csplru_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid           = (state_reg == csplru_pkg::ST_DONE);
    assign rsp.hit             = o_hit_reg;
    assign rsp.read_data       = o_rdata_reg;
    assign rsp.writeback_valid = o_wbv_reg;
    assign rsp.writeback_tag   = o_wbtag_reg;
    assign rsp.writeback_data  = o_wbdata_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csplru_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == csplru_pkg::CMD_TICK)
                    begin
                        state_next = csplru_pkg::ST_TICK;
                    end
                    else if (req.cmd == csplru_pkg::CMD_NOP)
                    begin
                        state_next = csplru_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = csplru_pkg::ST_SCAN_RD;
                    end
                end
            end
            csplru_pkg::ST_TICK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = csplru_pkg::ST_DONE;
                end
            end
            csplru_pkg::ST_SCAN_RD:
            begin
                state_next = csplru_pkg::ST_SCAN_CMP;
            end
            csplru_pkg::ST_SCAN_CMP:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = csplru_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = csplru_pkg::ST_SCAN_RD;
                end
            end
            csplru_pkg::ST_FETCH:
            begin
                state_next = csplru_pkg::ST_UPDATE;
            end
            csplru_pkg::ST_UPDATE:
            begin
                state_next = csplru_pkg::ST_TOUCH;
            end
            csplru_pkg::ST_TOUCH:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = csplru_pkg::ST_DONE;
                end
            end
            csplru_pkg::ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = csplru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csplru_pkg::ST_IDLE;
            end
        endcase
    end

    assign new_block = (cmd_reg == csplru_pkg::CMD_WRITE) ? wdata_reg :
                       (hit_reg ? old_block : fdata_reg);

    // datapath and outputs
    always_comb
    begin
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        tag_next       = tag_reg;
        wdata_next     = wdata_reg;
        fdata_next     = fdata_reg;
        ttl_next       = ttl_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        high_next      = high_reg;
        life_next      = life_reg;
        rank_next      = rank_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        pos_rank_next  = pos_rank_reg;
        vic_found_next = vic_found_reg;
        vic_inv_next   = vic_inv_reg;
        vic_low_next   = vic_low_reg;
        vic_dirty_next = vic_dirty_reg;
        vic_next       = vic_reg;
        vic_rank_next  = vic_rank_reg;
        w_next         = w_reg;
        w_rank_next    = w_rank_reg;
        fresh_next     = fresh_reg;
        o_hit_next     = o_hit_reg;
        o_rdata_next   = o_rdata_reg;
        o_wbv_next     = o_wbv_reg;
        o_wbtag_next   = o_wbtag_reg;
        o_wbdata_next  = o_wbdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = w_reg;
        ram_wdata      = {tag_reg, new_block};
        ram_raddr      = idx_reg;

        if (cfg.valid)
        begin
            ttl_next = TTL_BITS'(cfg.data);
        end

        case (state_reg)
            csplru_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.cmd;
                    tag_next       = req.tag;
                    wdata_next     = req.write_data;
                    fdata_next     = req.fill_data;
                    idx_next       = '0;
                    hit_next       = 1'b0;
                    vic_found_next = 1'b0;
                    vic_inv_next   = 1'b0;
                    o_hit_next     = 1'b0;
                    o_rdata_next   = '0;
                    o_wbv_next     = 1'b0;
                    o_wbtag_next   = '0;
                    o_wbdata_next  = '0;
                end
            end
            csplru_pkg::ST_TICK:
            begin
                high_next[idx_reg] = tick_high;
                life_next[idx_reg] = tick_life;
                idx_next           = idx_reg + IDX_BITS'(1);
            end
            csplru_pkg::ST_SCAN_RD:
            begin
                ram_raddr = idx_reg;
            end
            csplru_pkg::ST_SCAN_CMP:
            begin
                // a later matching way overrides an earlier one
                if (stat.match)
                begin
                    hit_next      = 1'b1;
                    pos_next      = idx_reg;
                    pos_rank_next = rank_reg[idx_reg];
                end
                if (!vic_inv_reg)
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        vic_inv_next   = 1'b1;
                        vic_found_next = 1'b1;
                        vic_next       = idx_reg;
                        vic_dirty_next = 1'b0;
                    end
                    else if (stat.better)
                    begin
                        vic_found_next = 1'b1;
                        vic_next       = idx_reg;
                        vic_low_next   = !high_reg[idx_reg];
                        vic_rank_next  = rank_reg[idx_reg];
                        vic_dirty_next = dirty_reg[idx_reg];
                    end
                end
                idx_next = idx_reg + IDX_BITS'(1);
            end
            csplru_pkg::ST_FETCH:
            begin
                ram_raddr   = hit_reg ? pos_reg : vic_reg;
                w_next      = hit_reg ? pos_reg : vic_reg;
                w_rank_next = hit_reg ? pos_rank_reg : vic_rank_reg;
                fresh_next  = !hit_reg && vic_inv_reg;
                idx_next    = '0;
            end
            csplru_pkg::ST_UPDATE:
            begin
                ram_we     = (cmd_reg == csplru_pkg::CMD_WRITE) || !hit_reg;
                o_hit_next = hit_reg;
                if (cmd_reg == csplru_pkg::CMD_READ)
                begin
                    o_rdata_next = new_block;
                end
                if (hit_reg)
                begin
                    high_next[w_reg] = 1'b1;
                    life_next[w_reg] = ttl_reg;
                    if (cmd_reg == csplru_pkg::CMD_WRITE)
                    begin
                        dirty_next[w_reg] = 1'b1;
                    end
                end
                else
                begin
                    if (!vic_inv_reg && vic_dirty_reg)
                    begin
                        o_wbv_next    = 1'b1;
                        o_wbtag_next  = old_tag;
                        o_wbdata_next = old_block;
                    end
                    valid_next[w_reg] = 1'b1;
                    high_next[w_reg]  = 1'b0;
                    life_next[w_reg]  = '0;
                    dirty_next[w_reg] = (cmd_reg == csplru_pkg::CMD_WRITE);
                end
            end
            csplru_pkg::ST_TOUCH:
            begin
                rank_next[idx_reg] = touch_rank;
                idx_next           = idx_reg + IDX_BITS'(1);
            end
            csplru_pkg::ST_DONE:
            begin
                idx_next = idx_reg;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csplru_pkg::ST_IDLE;
            ttl_reg   <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            high_reg  <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                life_reg[i] <= '0;
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ttl_reg   <= ttl_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            high_reg  <= high_next;
            life_reg  <= life_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        tag_reg       <= tag_next;
        wdata_reg     <= wdata_next;
        fdata_reg     <= fdata_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        pos_rank_reg  <= pos_rank_next;
        vic_found_reg <= vic_found_next;
        vic_inv_reg   <= vic_inv_next;
        vic_low_reg   <= vic_low_next;
        vic_dirty_reg <= vic_dirty_next;
        vic_reg       <= vic_next;
        vic_rank_reg  <= vic_rank_next;
        w_reg         <= w_next;
        w_rank_reg    <= w_rank_next;
        fresh_reg     <= fresh_next;
        o_hit_reg     <= o_hit_next;
        o_rdata_reg   <= o_rdata_next;
        o_wbv_reg     <= o_wbv_next;
        o_wbtag_reg   <= o_wbtag_next;
        o_wbdata_reg  <= o_wbdata_next;
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            rank_one[i] = valid_reg[i] && (rank_reg[i] == RANK_BITS'(1));
        end
    end

    // at most one valid way is most recent between items
    a_one_mru: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csplru_pkg::ST_IDLE) |-> $onehot0(rank_one))
        else $error("more than one most recent way");

    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.writeback_valid))
        else $error("writeback on a hit");

    a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (cmd_reg == csplru_pkg::CMD_TICK || cmd_reg == csplru_pkg::CMD_NOP))
        |-> (!rsp.hit && !rsp.writeback_valid && rsp.read_data == '0))
        else $error("tick or no-op item gave a nonzero result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while busy");

endmodule

// ----- sim/cache_set_priority_lru_top_tb.sv -----
`timescale 1ns / 100ps

module cache_set_priority_lru_top_tb;

    localparam int WAYS      = csplru_pkg::WAYS;
    localparam int TAG_BITS  = csplru_pkg::TAG_BITS;
    localparam int DATA_BITS = csplru_pkg::DATA_BITS;
    localparam int TTL_BITS  = csplru_pkg::TTL_BITS;
    localparam int CFG_BITS  = csplru_pkg::CFG_BITS;
    localparam int CMD_BITS  = csplru_pkg::CMD_BITS;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3 * WAYS + 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 6;
    localparam int POOL_SIZE    = 6;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 250;
    localparam int NUM_ROWS     = 25;

    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_data;
        logic                 wb_valid;
        logic [TAG_BITS-1:0]  wb_tag;
        logic [DATA_BITS-1:0] wb_data;
    } result_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [TAG_BITS-1:0]  tag;
        logic [DATA_BITS-1:0] wdata;
        logic [DATA_BITS-1:0] fdata;
        logic                 fixed;
        result_t              want;
    } stim_row_t;

    localparam result_t NONE = '0;

    // rows 0..7 and the last have results that follow from reset state directly
    localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
        '{csplru_pkg::CMD_READ,  20'h00000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 1'b0, 20'h0, 32'h0}},
        '{csplru_pkg::CMD_READ,  20'hFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h00000, 32'hA5A5_A5A5, 32'h1234_5678, 1'b1,
          '{1'b1, 32'h0, 1'b0, 20'h0, 32'h0}},
        '{csplru_pkg::CMD_READ,  20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{1'b1, 32'hA5A5_A5A5, 1'b0, 20'h0, 32'h0}},
        '{csplru_pkg::CMD_TICK,  20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NONE},
        '{csplru_pkg::CMD_NOP,   20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h12345, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b1, NONE},
        '{csplru_pkg::CMD_READ,  20'h00001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
          '{1'b0, 32'h1, 1'b0, 20'h0, 32'h0}},
        '{csplru_pkg::CMD_WRITE, 20'h0ABCD, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h22222, 32'h0000_0000, 32'h1357_9BDF, 1'b0, NONE},
        '{csplru_pkg::CMD_TICK,  20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_TICK,  20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h0ABCD, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_WRITE, 20'hFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h00003, 32'h3333_3333, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h00004, 32'h4444_4444, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h00005, 32'h5555_5555, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_WRITE, 20'h00006, 32'h6666_6666, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h00004, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h00005, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h00006, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_READ,  20'h0ABCD, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        // every way is high priority here, so the victim comes from the high ones
        '{csplru_pkg::CMD_READ,  20'h00007, 32'h0000_0000, 32'h7777_7777, 1'b0, NONE},
        '{csplru_pkg::CMD_TICK,  20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b0, NONE},
        '{csplru_pkg::CMD_NOP,   20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b1, NONE}
    };

    logic clk;
    logic rst_n;

    csplru_req_if req_ch ();
    csplru_rsp_if rsp_ch ();
    csplru_cfg_if cfg_ch ();

    cache_set_priority_lru_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the set
    logic                 line_valid [WAYS];
    logic                 line_dirty [WAYS];
    logic                 line_high  [WAYS];
    logic [TAG_BITS-1:0]  line_tag   [WAYS];
    logic [DATA_BITS-1:0] line_data  [WAYS];
    logic [TTL_BITS-1:0]  line_life  [WAYS];
    logic [4:0]           line_rank  [WAYS];
    logic [CFG_BITS-1:0]  hit_ttl;

    result_t pending_results [$];

    int  mismatch_count;
    int  accepted_count;
    int  result_count;
    int  hit_count;
    int  writeback_count;
    int  ttl_settings;
    int  cycle_count;
    bit  idle_on;
    bit  long_hold_done;

    logic [TAG_BITS-1:0] tag_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // make way w most recent; with fresh every other valid way ages
    function automatic void touch_way(int w, logic fresh);
        for (int i = 0; i < WAYS; i++)
        begin
            if (i != w && line_valid[i] && (fresh || line_rank[i] < line_rank[w]))
                line_rank[i] = line_rank[i] + 5'd1;
        end
        line_rank[w] = 5'd1;
    endfunction

    function automatic int pick_victim();
        int  best;
        logic best_low;
        logic low;
        best = -1;
        best_low = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!line_valid[i])
                return i;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            low = !line_high[i];
            if (best < 0 || (low && !best_low) ||
                (low == best_low && line_rank[i] > line_rank[best]))
            begin
                best = i;
                best_low = low;
            end
        end
        return best;
    endfunction

    function automatic result_t cache_access(logic [CMD_BITS-1:0] cmd,
                                             logic [TAG_BITS-1:0] tag,
                                             logic [DATA_BITS-1:0] wdata,
                                             logic [DATA_BITS-1:0] fdata);
        result_t r;
        int      pos;
        int      vic;
        logic    was_valid;
        r = '0;
        pos = -1;
        if (cmd == csplru_pkg::CMD_NOP)
            return r;
        if (cmd == csplru_pkg::CMD_TICK)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (line_valid[i] && line_high[i])
                begin
                    if (line_life[i] == '0)
                        line_high[i] = 1'b0;
                    else
                        line_life[i] = line_life[i] - TTL_BITS'(1);
                end
            end
            return r;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (line_valid[i] && line_tag[i] == tag)
                pos = i;
        end
        if (pos >= 0)
        begin
            line_high[pos] = 1'b1;
            line_life[pos] = hit_ttl[TTL_BITS-1:0];
            if (cmd == csplru_pkg::CMD_WRITE)
            begin
                line_data[pos]  = wdata;
                line_dirty[pos] = 1'b1;
            end
            touch_way(pos, 1'b0);
            r.hit = 1'b1;
            if (cmd == csplru_pkg::CMD_READ)
                r.read_data = line_data[pos];
            return r;
        end
        vic = pick_victim();
        was_valid = line_valid[vic];
        if (was_valid && line_dirty[vic])
        begin
            r.wb_valid = 1'b1;
            r.wb_tag   = line_tag[vic];
            r.wb_data  = line_data[vic];
        end
        line_valid[vic] = 1'b1;
        line_high[vic]  = 1'b0;
        line_life[vic]  = '0;
        line_tag[vic]   = tag;
        if (cmd == csplru_pkg::CMD_WRITE)
        begin
            line_data[vic]  = wdata;
            line_dirty[vic] = 1'b1;
        end
        else
        begin
            line_data[vic]  = fdata;
            line_dirty[vic] = 1'b0;
            r.read_data     = fdata;
        end
        touch_way(vic, !was_valid);
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [DATA_BITS-1:0] want,
                                 input logic [DATA_BITS-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $realtime, what, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: result with nothing expected, actual hit %b data %h", $realtime,
                     rsp_ch.hit, rsp_ch.read_data);
            return;
        end
        want = pending_results.pop_front();
        result_count++;
        if (rsp_ch.hit === 1'b1)
            hit_count++;
        if (rsp_ch.writeback_valid === 1'b1)
            writeback_count++;
        compare_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
        compare_field("read_data", want.read_data, rsp_ch.read_data);
        compare_field("writeback_valid", 32'(want.wb_valid), 32'(rsp_ch.writeback_valid));
        compare_field("writeback_tag", 32'(want.wb_tag), 32'(rsp_ch.writeback_tag));
        compare_field("writeback_data", want.wb_data, rsp_ch.writeback_data);
    endtask

    task automatic offer_item(input logic [CMD_BITS-1:0] cmd, input logic [TAG_BITS-1:0] tag,
                              input logic [DATA_BITS-1:0] wdata,
                              input logic [DATA_BITS-1:0] fdata,
                              input logic fixed, input result_t want);
        result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.tag        <= tag;
        req_ch.write_data <= wdata;
        req_ch.fill_data  <= fdata;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = cache_access(cmd, tag, wdata, fdata);
        pending_results.push_back(fixed ? want : predicted);
        accepted_count++;
    endtask

    task automatic set_ttl(input logic [CFG_BITS-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        hit_ttl = value;
        ttl_settings++;
    endtask

    task automatic random_item();
        logic [CMD_BITS-1:0] cmd;
        logic [TAG_BITS-1:0] tag;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            cmd = csplru_pkg::CMD_READ;
        else if (pick < 75)
            cmd = csplru_pkg::CMD_WRITE;
        else if (pick < 90)
            cmd = csplru_pkg::CMD_TICK;
        else
            cmd = csplru_pkg::CMD_NOP;
        // a small pool of live tags keeps hits and evictions frequent
        if ($urandom_range(0, 49) == 0)
            tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_BITS'($urandom);
        if ($urandom_range(0, 99) < 85)
            tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            tag = TAG_BITS'($urandom);
        offer_item(cmd, tag, $urandom, $urandom, 1'b0, NONE);
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : rsp_side
        int gap;
        gap = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            if (gap > 0)
            begin
                gap--;
                if (gap == 0)
                    rsp_ch.ready <= 1'b1;
            end
            else if (!long_hold_done && accepted_count >= HOLD_AT)
            begin
                // long hold: the set stalls in ST_DONE and must push back on requests
                rsp_ch.ready <= 1'b0;
                gap = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap = $urandom_range(1, 14);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : req_side
        logic [CFG_BITS-1:0] ttl_plan [NUM_PHASES];
        clk = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= csplru_pkg::CMD_READ;
        req_ch.tag        <= '0;
        req_ch.write_data <= '0;
        req_ch.fill_data  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        mismatch_count  = 0;
        accepted_count  = 0;
        result_count    = 0;
        hit_count       = 0;
        writeback_count = 0;
        ttl_settings    = 0;
        idle_on         = 1'b1;
        long_hold_done  = 1'b0;
        hit_ttl         = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_high[i]  = 1'b0;
            line_tag[i]   = '0;
            line_data[i]  = '0;
            line_life[i]  = '0;
            line_rank[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = TAG_BITS'($urandom);
        ttl_plan = '{8'd255, 8'd1, 8'd3, CFG_BITS'($urandom_range(0, 255)), 8'd0, 8'd2};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            offer_item(DIR_ROWS[i].cmd, DIR_ROWS[i].tag, DIR_ROWS[i].wdata,
                       DIR_ROWS[i].fdata, DIR_ROWS[i].fixed, DIR_ROWS[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_ttl(ttl_plan[p]);
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items, %0d results checked under %0d ttl settings",
                 accepted_count, result_count, ttl_settings);
        $display("results held %0d hits and %0d dirty writebacks", hit_count, writeback_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
